// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, masked while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, masked while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/aes_pkg.sv =====
// AES constants, byte tables and round helper functions
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int NUM_STAGES = NUM_ROUNDS + 1;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic   valid;
        logic   kind;
        block_t state;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t sub_shift(input block_t s, input logic inv);
        block_t t;
        int     r;
        int     c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                if (inv)
                    t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] =
                        INV_SBOX[get_byte(s, r + 4 * c)];
                else
                    t[127 - 8 * (r + 4 * c) -: 8] =
                        SBOX[get_byte(s, r + 4 * ((c + r) & 3))];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_fwd(input block_t s);
        block_t     t;
        logic [7:0] a0, a1, a2, a3;
        int         c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 32 * c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[103 - 32 * c -: 8]  = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return t;
    endfunction

    // inverse mix = forward mix after a pre-step with 4x/5x terms
    function automatic block_t mix_inv(input block_t s);
        block_t     t;
        logic [7:0] a0, a1, a2, a3, u, v;
        int         c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            u  = xt(xt(a0 ^ a2));
            v  = xt(xt(a1 ^ a3));
            t[127 - 32 * c -: 8] = a0 ^ u;
            t[119 - 32 * c -: 8] = a1 ^ v;
            t[111 - 32 * c -: 8] = a2 ^ u;
            t[103 - 32 * c -: 8] = a3 ^ v;
        end
        return mix_fwd(t);
    endfunction

    function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== sv/aes128_block_cipher_enc_dec.sv =====
// AES-128 ECB encrypt/decrypt engine, one round per pipeline stage
// From accepted item to result valid: input AddRoundKey, 10 rounds, output register.
// Throughput: one item per cycle unless stalled; ten round stages, fully pipelined.
// Stall: all stages hold while the output register is full and not taken.
// Reset: rst_n async low clears valid bits and the key to zero.
// After reset or a key write, in_ready stays low while the key schedule settles.
module aes128_block_cipher_enc_dec
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);
    import aes_pkg::*;
`include "assert_macros.svh"

    localparam logic CFG_KEY_HI = 1'b0;
    localparam logic CFG_KEY_LO = 1'b1;

    logic [63:0] key_hi_reg;
    logic [63:0] key_lo_reg;
    logic [3:0]  settle_reg;
    block_t      rkeys [NUM_STAGES];
    stage_t      st_reg [NUM_STAGES + 1];
    logic        adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_HI: key_hi_reg <= cfg_data;
                CFG_KEY_LO: key_lo_reg <= cfg_data;
                default:    key_hi_reg <= key_hi_reg;
            endcase
        end
    end

    // counts down while the registered round keys catch up with the key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 4'(NUM_STAGES);
        else if (cfg_we)
            settle_reg <= 4'(NUM_STAGES);
        else if (settle_reg != '0)
            settle_reg <= settle_reg - 4'd1;
    end

    aes_keys u_keys
    (
        .clk   (clk),
        .rst_n (rst_n),
        .key   ({key_hi_reg, key_lo_reg}),
        .rkeys (rkeys)
    );

    // whole pipe moves together; a bubble at the output lets it move
    assign adv      = !st_reg[NUM_STAGES].valid || out_ready;
    assign in_ready = adv && (settle_reg == '0);

    // stage 0: first AddRoundKey. Stages 1..10: one round each.
    // Decrypt uses the round keys in reverse order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NUM_STAGES; i++)
                st_reg[i].valid <= 1'b0;
        end
        else if (adv)
        begin
            st_reg[0].valid <= in_valid && in_ready;
            st_reg[0].kind  <= kind;
            st_reg[0].state <= {block_hi, block_lo} ^ (kind ? rkeys[NUM_ROUNDS] : rkeys[0]);
            for (int i = 1; i <= NUM_ROUNDS; i++)
            begin
                st_reg[i].valid <= st_reg[i - 1].valid;
                st_reg[i].kind  <= st_reg[i - 1].kind;
                if (!st_reg[i - 1].kind)
                begin
                    if (i == NUM_ROUNDS)
                        st_reg[i].state <= sub_shift(st_reg[i - 1].state, 1'b0) ^ rkeys[i];
                    else
                        st_reg[i].state <= mix_fwd(sub_shift(st_reg[i - 1].state, 1'b0))
                                           ^ rkeys[i];
                end
                else
                begin
                    if (i == NUM_ROUNDS)
                        st_reg[i].state <= sub_shift(st_reg[i - 1].state, 1'b1)
                                           ^ rkeys[0];
                    else
                        st_reg[i].state <= mix_inv(sub_shift(st_reg[i - 1].state, 1'b1)
                                                   ^ rkeys[NUM_ROUNDS - i]);
                end
            end
            st_reg[NUM_STAGES] <= st_reg[NUM_ROUNDS];
        end
    end

    assign out_valid = st_reg[NUM_STAGES].valid;
    assign result_hi = st_reg[NUM_STAGES].state[127:64];
    assign result_lo = st_reg[NUM_STAGES].state[63:0];

    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_hi))
    `ASSERT_IMPL(a_ready, clk, rst_n, !out_valid && settle_reg == '0, in_ready)
    `ASSERT_NEXT(a_enter, clk, rst_n, in_valid && in_ready, st_reg[0].valid)
endmodule

// ===== sv/aes_keys.sv =====
// Round key schedule, registered per round, rebuilt after each key write
module aes_keys
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [127:0]         key,
    output aes_pkg::block_t      rkeys [aes_pkg::NUM_STAGES]
);
    import aes_pkg::*;

    block_t rk_reg [NUM_STAGES];

    // one round key per stage, each registered from the one before
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
                rk_reg[i] <= '0;
        end
        else
        begin
            rk_reg[0] <= key;
            for (int i = 1; i < NUM_STAGES; i++)
                rk_reg[i] <= next_round_key(rk_reg[i - 1], RCON[i - 1]);
        end
    end

    assign rkeys = rk_reg;
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the AES-128 ECB encrypt/decrypt engine
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    // Register indexes of the configuration port
    localparam logic REG_KEY_HI = 1'b0;
    localparam logic REG_KEY_LO = 1'b1;
    // Operation encodings of the kind field
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // The key schedule is registered and must settle before use; leave margin
    localparam int KEY_SETTLE = 16;
    // Pipeline is 12 deep; used for every drain
    localparam int PIPE_DEPTH = 12;
    localparam int RANDOM_ITEMS = 450;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;

    aes128_block_cipher_enc_dec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .block_hi  (block_hi),
        .block_lo  (block_lo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result_hi (result_hi),
        .result_lo (result_lo)
    );

    // Predictor copy of the key registers, updated as each write lands
    logic [63:0] key_hi_q;
    logic [63:0] key_lo_q;

    // Expected output blocks, oldest first
    logic [127:0] cipher_fifo[$];
    int           error_count;

    // Idle rates in percent, set per phase by the stimulus process
    int  sender_gap_pct;
    int  recv_stall_pct;
    // Request for a long receiver hold-off; the receiver owns the count
    bit  hold_req;
    int  hold_left;

    // ------------------------------------------------------------------
    // AES predictor; byte i of a block lives at bits [127-8i -: 8]
    // ------------------------------------------------------------------
    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        int         i;
        acc = 8'h00;
        x   = a;
        for (i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x;
            x = gf_double(x);
        end
        return acc;
    endfunction

    // SubBytes+ShiftRows, or their inverses
    function automatic logic [127:0] bytes_rotate_sub(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int           r;
        int           c;
        int           src;
        int           dst;
        t = '0;
        for (c = 0; c < 4; c++)
        begin
            for (r = 0; r < 4; r++)
            begin
                if (inv)
                begin
                    src = r + 4 * c;
                    dst = r + 4 * ((c + r) % 4);
                    t[127 - 8 * dst -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
                end
                else
                begin
                    dst = r + 4 * c;
                    src = r + 4 * ((c + r) % 4);
                    t[127 - 8 * dst -: 8] = SBOX[s[127 - 8 * src -: 8]];
                end
            end
        end
        return t;
    endfunction

    // MixColumns by the full circulant matrix product
    function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inv);
        logic [7:0]   coef [4];
        logic [7:0]   acc;
        logic [127:0] t;
        int           c;
        int           r;
        int           j;
        if (inv)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        t = '0;
        for (c = 0; c < 4; c++)
        begin
            for (r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (j = 0; j < 4; j++)
                    acc ^= gf_product(s[127 - 8 * (4 * c + j) -: 8], coef[(j - r + 4) % 4]);
                t[127 - 8 * (4 * c + r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] aes_transform(input logic op, input logic [127:0] din,
                                                   input logic [127:0] key);
        logic [127:0] rkey [11];
        logic [31:0]  w;
        logic [31:0]  w0, w1, w2, w3;
        logic [7:0]   rcon;
        logic [127:0] s;
        int           rnd;
        rkey[0] = key;
        rcon    = 8'h01;
        for (rnd = 1; rnd <= 10; rnd++)
        begin
            w0 = rkey[rnd-1][127:96];
            w1 = rkey[rnd-1][95:64];
            w2 = rkey[rnd-1][63:32];
            w3 = rkey[rnd-1][31:0];
            // RotWord then SubWord, round constant on the top byte
            w  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
            w0 = w0 ^ w;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            rkey[rnd] = {w0, w1, w2, w3};
            rcon = gf_double(rcon);
        end
        s = din;
        if (op == OP_ENCRYPT)
        begin
            s ^= rkey[0];
            for (rnd = 1; rnd < 10; rnd++)
                s = column_mix(bytes_rotate_sub(s, 1'b0), 1'b0) ^ rkey[rnd];
            s = bytes_rotate_sub(s, 1'b0) ^ rkey[10];
        end
        else
        begin
            s ^= rkey[10];
            for (rnd = 9; rnd >= 1; rnd--)
                s = column_mix(bytes_rotate_sub(s, 1'b1) ^ rkey[rnd], 1'b1);
            s = bytes_rotate_sub(s, 1'b1) ^ rkey[0];
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on input accept, compare on output accept.
    // Sampled at the rising edge, before the block's own updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                cipher_fifo.push_back(aes_transform(kind, {block_hi, block_lo},
                                                    {key_hi_q, key_lo_q}));
            if (out_valid && out_ready)
            begin
                if (cipher_fifo.size() == 0)
                begin
                    $error("result item with nothing expected: %h %h", result_hi, result_lo);
                    error_count++;
                end
                else
                begin
                    want = cipher_fifo.pop_front();
                    if (result_hi !== want[127:64])
                    begin
                        $error("result_hi expected %h actual %h", want[127:64], result_hi);
                        error_count++;
                    end
                    if (result_lo !== want[63:0])
                    begin
                        $error("result_lo expected %h actual %h", want[63:0], result_lo);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offers one item and returns once it is accepted
    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        @(negedge clk);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = op;
        block_hi = hi;
        block_lo = lo;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Waits for every expected result, then for the pipe to go quiet
    task automatic drain_pipe();
        @(negedge clk);
        in_valid = 1'b0;
        while (cipher_fifo.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    // Key load while idle, then time for the key schedule to settle
    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        drain_pipe();
        cfg_we    = 1'b1;
        cfg_index = REG_KEY_HI;
        cfg_data  = hi;
        @(negedge clk);
        cfg_index = REG_KEY_LO;
        cfg_data  = lo;
        key_hi_q  = hi;
        @(negedge clk);
        cfg_we    = 1'b0;
        key_lo_q  = lo;
        repeat (KEY_SETTLE) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly random words, with some edge patterns mixed in
    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(63);
            default: return rand64();
        endcase
    endfunction

    // Directed item table
    typedef struct {
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        logic         op;
        logic [63:0]  hi;
        logic [63:0]  lo;
        bit           known;
        logic [127:0] expected;
    } vector_t;

    vector_t vectors[$];

    task automatic add_vec(input logic [63:0] kh, input logic [63:0] kl, input logic op,
                           input logic [63:0] hi, input logic [63:0] lo,
                           input bit known, input logic [127:0] expected);
        vector_t v;
        v.key_hi = kh; v.key_lo = kl; v.op = op; v.hi = hi; v.lo = lo;
        v.known = known; v.expected = expected;
        vectors.push_back(v);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [63:0]  kh;
        logic [63:0]  kl;
        logic [127:0] got;
        int           phase;
        int           n;
        int           i;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_KEY_HI;
        cfg_data  = '0;
        in_valid  = 1'b0;
        kind      = OP_ENCRYPT;
        block_hi  = '0;
        block_lo  = '0;
        out_ready = 1'b0;
        key_hi_q  = '0;
        key_lo_q  = '0;
        error_count    = 0;
        sender_gap_pct = 0;
        recv_stall_pct = 0;
        hold_req  = 1'b0;
        hold_left = 0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (KEY_SETTLE) @(negedge clk);

        // Zero key straight after reset: known all-zero vector and its inverse
        add_vec('0, '0, OP_ENCRYPT, '0, '0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        add_vec('0, '0, OP_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, '0);
        add_vec('0, '0, OP_ENCRYPT, '1, '1, 0, '0);
        add_vec('0, '0, OP_DECRYPT, '1, '1, 0, '0);
        // Standard example key and plaintext, both directions
        add_vec(64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENCRYPT,
                64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        add_vec(64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_DECRYPT,
                64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                128'h00112233445566778899aabbccddeeff);
        add_vec(64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENCRYPT,
                64'h8000000000000000, 64'h1, 0, '0);
        add_vec(64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_DECRYPT,
                '0, '0, 0, '0);
        // All-ones key
        add_vec('1, '1, OP_ENCRYPT, '0, '0, 0, '0);
        add_vec('1, '1, OP_DECRYPT, '0, '0, 0, '0);
        add_vec('1, '1, OP_ENCRYPT, '1, '1, 0, '0);
        add_vec('1, '1, OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0, '0);

        kh = '0;
        kl = '0;
        foreach (vectors[i])
        begin
            if (vectors[i].key_hi != kh || vectors[i].key_lo != kl)
            begin
                kh = vectors[i].key_hi;
                kl = vectors[i].key_lo;
                load_key(kh, kl);
            end
            // typed-in results are cross-checked against the predictor
            if (vectors[i].known)
            begin
                got = aes_transform(vectors[i].op, {vectors[i].hi, vectors[i].lo}, {kh, kl});
                if (got !== vectors[i].expected)
                begin
                    $error("known vector %0d expected %h predicted %h",
                           i, vectors[i].expected, got);
                    error_count++;
                end
            end
            send_block(vectors[i].op, vectors[i].hi, vectors[i].lo);
        end

        // Random part: a new key per phase, idle pattern rotates
        n = 0;
        phase = 0;
        while (n < RANDOM_ITEMS)
        begin
            case (phase % 5)
                0: begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_gap_pct = 52; recv_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  recv_stall_pct = 52; end
                3: begin sender_gap_pct = 17; recv_stall_pct = 17; end
                default: begin sender_gap_pct = 0; recv_stall_pct = 10; end
            endcase
            if (phase == 2)
                load_key('1, '0);
            else if (phase == 6)
                load_key('0, '1);
            else
                load_key(rand64(), rand64());
            // full-rate sender against a held-off receiver fills the pipe
            if (phase % 5 == 4)
                hold_req = 1'b1;
            for (i = 0; i < 50 && n < RANDOM_ITEMS; i++)
            begin
                send_block($urandom_range(1), pick_word(), pick_word());
                n++;
            end
            phase++;
        end

        drain_pipe();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== aes128_block_cipher_enc_dec.f =====
+incdir+sv
sv/aes_pkg.sv
sv/aes_keys.sv
sv/aes128_block_cipher_enc_dec.sv
tb/sv/testbench.sv
